// File: design/tsd_pkg.sv
// ----------------------------------------------------------------------------
// Tape sub-block descrambler package
// Types, key tables and constants shared by the descrambler core and top level.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int KEY_LEN_A = 207;
    localparam int KEY_LEN_B = 220;

    localparam logic [7:0]  BAD_BYTE  = 8'h69;
    localparam logic [7:0]  BYTE_MAX  = 8'hFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [8:0]  FULL_SIZE = 9'h100;

    // Result kinds carried on m_tuser.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_STATUS  = 2'd1,
        KIND_FORMAT  = 2'd2
    } tsd_kind_t;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_PAYLOAD = 6'b000010,
        PH_EXEC_LO = 6'b000100,
        PH_EXEC_HI = 6'b001000,
        PH_CHECK   = 6'b010000,
        PH_IDLE    = 6'b100000
    } tsd_phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       read_error;
        logic       frame_start;
    } tsd_item_t;

    typedef struct packed {
        tsd_kind_t   result_kind;
        logic [7:0]  data_value;
        logic [15:0] byte_addr;
        logic        byte_bad;
        logic [7:0]  block_number;
        logic [15:0] exec_addr;
        logic        exec_valid;
        logic [7:0]  sum_expected;
        logic [7:0]  sum_read;
        logic        sum_ok;
        logic [15:0] error_total;
    } tsd_result_t;

    localparam logic [7:0] KEY_A [0:KEY_LEN_A-1] = '{
        8'h78,8'hA9,8'hD1,8'h8D,8'hFA,8'hFF,8'h8D,8'hFE,8'hFF,8'hA9,8'h00,8'h8D,8'hFB,8'hFF,8'h8D,8'hFF,
        8'hFF,8'hA9,8'h7F,8'h8D,8'h0D,8'hDC,8'h8D,8'h0D,8'hDD,8'hAD,8'h0D,8'hDC,8'hAD,8'h0D,8'hDD,8'hA9,
        8'h60,8'h8D,8'h04,8'hDD,8'hA9,8'h01,8'h8D,8'h05,8'hDD,8'hA9,8'h00,8'h8D,8'h20,8'hD0,8'h85,8'hFF,
        8'h85,8'hF6,8'hA9,8'h19,8'h8D,8'h0E,8'hDD,8'h20,8'hBE,8'h00,8'h66,8'hFC,8'hA5,8'hFC,8'hC9,8'hE3,
        8'hD0,8'hF5,8'h20,8'hB1,8'h00,8'hC9,8'hE3,8'hF0,8'hF9,8'hC9,8'hED,8'hD0,8'hEA,8'h20,8'hB1,8'h00,
        8'h85,8'hFA,8'h20,8'hB1,8'h00,8'h85,8'hFD,8'h20,8'hB1,8'h00,8'h85,8'hFE,8'h20,8'hB1,8'h00,8'h85,
        8'hFB,8'hA0,8'h00,8'h20,8'hB1,8'h00,8'hA6,8'hF6,8'h55,8'h02,8'hE8,8'hE0,8'hCF,8'hD0,8'h02,8'hA2,
        8'h00,8'h86,8'hF6,8'h45,8'hFE,8'h45,8'hFD,8'hC6,8'h01,8'h91,8'hFD,8'hE6,8'h01,8'h45,8'hFF,8'h85,
        8'hFF,8'hE6,8'hFD,8'hD0,8'h02,8'hE6,8'hFE,8'hC6,8'hFB,8'hD0,8'hD6,8'hC6,8'hFA,8'hD0,8'hBE,8'h20,
        8'hB1,8'h00,8'h85,8'hF7,8'h20,8'hB1,8'h00,8'h85,8'hF8,8'h20,8'hB1,8'h00,8'hC5,8'hFF,8'hD0,8'h03,
        8'h6C,8'hF7,8'h00,8'hAD,8'h20,8'hD0,8'h18,8'h69,8'h04,8'h8D,8'h20,8'hD0,8'h4C,8'hA5,8'h00,8'hA2,
        8'h08,8'h20,8'hBE,8'h00,8'h66,8'hFC,8'hCA,8'hD0,8'hF8,8'hA5,8'hFC,8'h60,8'hA9,8'h10,8'h2C,8'h0D,
        8'hDC,8'hF0,8'hFB,8'h4E,8'h0D,8'hDD,8'hA9,8'h19,8'h8D,8'h0E,8'hDD,8'hEE,8'h20,8'hD0,8'h60
    };

    localparam logic [7:0] KEY_B [0:KEY_LEN_B-1] = '{
        8'h78,8'hA9,8'hE7,8'h8D,8'hFA,8'hFF,8'h8D,8'hFE,8'hFF,8'hA9,8'h00,8'h8D,8'hFB,8'hFF,8'h8D,8'hFF,
        8'hFF,8'hA2,8'h43,8'h9A,8'hAD,8'hFD,8'hFF,8'h48,8'hA2,8'hFF,8'h9A,8'hA9,8'h7F,8'h8D,8'h0D,8'hDC,
        8'h8D,8'h0D,8'hDD,8'hAD,8'h0D,8'hDC,8'hAD,8'h0D,8'hDD,8'hA9,8'h60,8'h8D,8'h04,8'hDD,8'hA9,8'h01,
        8'h8D,8'h05,8'hDD,8'hA9,8'h00,8'h8D,8'h20,8'hD0,8'h8D,8'h11,8'hD0,8'h85,8'h0A,8'h85,8'h02,8'hA9,
        8'h19,8'h8D,8'h0E,8'hDD,8'h20,8'hD7,8'h00,8'h66,8'h07,8'hA5,8'h07,8'hC9,8'hE3,8'hD0,8'hF5,8'h20,
        8'hCA,8'h00,8'hC9,8'hE3,8'hF0,8'hF9,8'hC9,8'hED,8'hD0,8'hEA,8'h20,8'hCA,8'h00,8'h85,8'h05,8'h20,
        8'hCA,8'h00,8'h85,8'h08,8'h20,8'hCA,8'h00,8'h85,8'h09,8'h20,8'hCA,8'h00,8'h85,8'h06,8'hA0,8'h00,
        8'h20,8'hCA,8'h00,8'hA6,8'h02,8'h55,8'h0B,8'hE8,8'hE0,8'hDC,8'hD0,8'h02,8'hA2,8'h00,8'h86,8'h02,
        8'h45,8'h09,8'h45,8'h08,8'hC6,8'h01,8'h91,8'h08,8'hE6,8'h01,8'h8D,8'h20,8'hD0,8'h45,8'h0A,8'h85,
        8'h0A,8'hE6,8'h08,8'hD0,8'h02,8'hE6,8'h09,8'hC6,8'h06,8'hD0,8'hD3,8'hC6,8'h05,8'hD0,8'hBB,8'h20,
        8'hCA,8'h00,8'h85,8'h03,8'h20,8'hCA,8'h00,8'h85,8'h04,8'h20,8'hCA,8'h00,8'hC5,8'h0A,8'hD0,8'h03,
        8'h6C,8'h03,8'h00,8'hAD,8'h20,8'hD0,8'h18,8'h69,8'h04,8'h8D,8'h20,8'hD0,8'h4C,8'hBE,8'h00,8'hA2,
        8'h08,8'h20,8'hD7,8'h00,8'h66,8'h07,8'hCA,8'hD0,8'hF8,8'hA5,8'h07,8'h60,8'hA9,8'h10,8'h2C,8'h0D,
        8'hDC,8'hF0,8'hFB,8'h4E,8'h0D,8'hDD,8'hA9,8'h19,8'h8D,8'h0E,8'hDD,8'h60
    };

endpackage

// File: design/tsd_core.sv
// ----------------------------------------------------------------------------
// Tape sub-block descrambler core
// Parses sub-block headers, descrambles payload bytes and builds the results.
// ----------------------------------------------------------------------------
module tsd_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                key_variant,
    input  tsd_pkg::tsd_item_t   item,
    output logic                has_result,
    output tsd_pkg::tsd_result_t result
);
    import tsd_pkg::*;

    localparam logic [8:0] LEN_A = 9'(KEY_LEN_A);
    localparam logic [8:0] LEN_B = 9'(KEY_LEN_B);

    tsd_phase_t  phase_reg,   phase_next;
    logic [1:0]  hpos_reg,    hpos_next;
    logic [7:0]  id_reg,      id_next;
    logic [15:0] addr_reg,    addr_next;
    logic [8:0]  left_reg,    left_next;
    logic [7:0]  kidx_reg,    kidx_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [15:0] err_reg,     err_next;
    logic [7:0]  exec_lo_reg, exec_lo_next;
    logic [7:0]  exec_hi_reg, exec_hi_next;
    logic [1:0]  exec_ok_reg, exec_ok_next;

    // State as seen after a frame start has cleared it.
    tsd_phase_t  eff_phase;
    logic [1:0]  eff_hpos;
    logic [7:0]  eff_kidx;
    logic [7:0]  eff_sum;
    logic [15:0] eff_err;
    logic [1:0]  eff_exec_ok;

    logic [7:0]  b;
    logic        bad;
    logic [8:0]  key_len;
    logic [7:0]  kidx;
    logic [8:0]  kidx_inc;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic [15:0] err_inc;
    logic [8:0]  size;
    logic [16:0] end_addr;
    logic [8:0]  left_dec;

    assign b   = item.byte_value;
    assign bad = item.read_error;

    always_comb begin
        if (item.frame_start) begin
            eff_phase   = PH_HEADER;
            eff_hpos    = 2'd0;
            eff_kidx    = 8'd0;
            eff_sum     = 8'd0;
            eff_err     = 16'd0;
            eff_exec_ok = 2'd0;
        end else begin
            eff_phase   = phase_reg;
            eff_hpos    = hpos_reg;
            eff_kidx    = kidx_reg;
            eff_sum     = sum_reg;
            eff_err     = err_reg;
            eff_exec_ok = exec_ok_reg;
        end
    end

    // An index left over from the other table restarts at the first entry.
    assign key_len  = key_variant ? LEN_B : LEN_A;
    assign kidx     = ({1'b0, eff_kidx} < key_len) ? eff_kidx : 8'd0;
    assign kidx_inc = {1'b0, kidx} + 9'd1;
    assign key_byte = key_variant ? KEY_B[kidx] : KEY_A[kidx];
    assign plain    = b ^ key_byte ^ addr_reg[15:8] ^ addr_reg[7:0];
    assign err_inc  = (eff_err == COUNT_MAX) ? eff_err : eff_err + 16'd1;
    assign size     = (b == 8'd0) ? FULL_SIZE : {1'b0, b};
    assign end_addr = {1'b0, addr_reg} + {8'd0, size} - 17'd1;
    assign left_dec = left_reg - 9'd1;

    always_comb begin
        phase_next   = eff_phase;
        hpos_next    = eff_hpos;
        id_next      = id_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        kidx_next    = eff_kidx;
        sum_next     = eff_sum;
        err_next     = eff_err;
        exec_lo_next = exec_lo_reg;
        exec_hi_next = exec_hi_reg;
        exec_ok_next = eff_exec_ok;
        has_result   = 1'b0;
        result       = '0;

        unique case (eff_phase)
            PH_HEADER: begin
                if (bad) begin
                    if (eff_hpos == 2'd0) begin
                        id_next = 8'd0;
                    end
                    phase_next = PH_IDLE;
                    has_result = 1'b1;
                end else begin
                    unique case (eff_hpos)
                        2'd0: begin
                            id_next = b;
                            if (b == 8'd0) begin
                                phase_next = PH_IDLE;
                                has_result = 1'b1;
                            end else begin
                                hpos_next = 2'd1;
                            end
                        end
                        2'd1: begin
                            addr_next = {8'd0, b};
                            hpos_next = 2'd2;
                        end
                        2'd2: begin
                            addr_next = {b, addr_reg[7:0]};
                            hpos_next = 2'd3;
                        end
                        default: begin
                            hpos_next = 2'd0;
                            if (end_addr[16]) begin
                                phase_next = PH_IDLE;
                                has_result = 1'b1;
                            end else begin
                                left_next  = size;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                result.result_kind  = KIND_FORMAT;
                result.block_number = id_next;
                result.error_total  = eff_err;
            end
            PH_PAYLOAD: begin
                has_result          = 1'b1;
                result.result_kind  = KIND_PAYLOAD;
                result.byte_addr    = addr_reg;
                result.block_number = id_reg;
                if (bad) begin
                    result.data_value = BAD_BYTE;
                    result.byte_bad   = 1'b1;
                    err_next          = err_inc;
                end else begin
                    result.data_value = plain;
                    sum_next          = eff_sum ^ plain;
                    kidx_next         = (kidx_inc >= key_len) ? 8'd0 : kidx_inc[7:0];
                end
                addr_next = addr_reg + 16'd1;
                left_next = left_dec;
                if (left_dec == 9'd0) begin
                    if (id_reg == 8'd1) begin
                        phase_next   = PH_EXEC_LO;
                        exec_ok_next = 2'd0;
                    end else begin
                        phase_next = PH_HEADER;
                        hpos_next  = 2'd0;
                    end
                end
            end
            PH_EXEC_LO: begin
                if (!bad) begin
                    exec_lo_next = b;
                    exec_ok_next = eff_exec_ok | 2'b01;
                end
                phase_next = PH_EXEC_HI;
            end
            PH_EXEC_HI: begin
                if (!bad) begin
                    exec_hi_next = b;
                    exec_ok_next = eff_exec_ok | 2'b10;
                end
                phase_next = PH_CHECK;
            end
            PH_CHECK: begin
                has_result          = 1'b1;
                result.result_kind  = KIND_STATUS;
                result.block_number = id_reg;
                if (eff_exec_ok == 2'b11) begin
                    result.exec_addr  = {exec_hi_reg, exec_lo_reg};
                    result.exec_valid = 1'b1;
                end
                result.sum_expected = eff_sum;
                if (bad) begin
                    err_next        = err_inc;
                    result.sum_read = BYTE_MAX;
                end else begin
                    result.sum_read = b;
                    result.sum_ok   = (b == eff_sum);
                end
                result.error_total = err_next;
                phase_next         = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hpos_reg    <= 2'd0;
            id_reg      <= 8'd0;
            addr_reg    <= 16'd0;
            left_reg    <= 9'd0;
            kidx_reg    <= 8'd0;
            sum_reg     <= 8'd0;
            err_reg     <= 16'd0;
            exec_lo_reg <= 8'd0;
            exec_hi_reg <= 8'd0;
            exec_ok_reg <= 2'd0;
        end else if (step) begin
            phase_reg   <= phase_next;
            hpos_reg    <= hpos_next;
            id_reg      <= id_next;
            addr_reg    <= addr_next;
            left_reg    <= left_next;
            kidx_reg    <= kidx_next;
            sum_reg     <= sum_next;
            err_reg     <= err_next;
            exec_lo_reg <= exec_lo_next;
            exec_hi_reg <= exec_hi_next;
            exec_ok_reg <= exec_ok_next;
        end
    end

endmodule

// File: design/tape_subblock_descrambler.sv
// An item waits in the input register until the core steps. Throughput: one item
// per cycle unless m_tready stalls; the input register feeds the core, whose
// single pass of table lookup, XORs and counter updates ends in the result register.
// Reset (aresetn low, synchronous) empties both registers, selects the first key
// table and starts parsing at a sub-block header with cleared counters.
// ----------------------------------------------------------------------------
// Tape sub-block descrambler
// Stream wrapper: input register, descrambler core and result register.
// ----------------------------------------------------------------------------
module tape_subblock_descrambler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // key_variant
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] byte_value
    input  logic [1:0]  s_tuser,       // [0] read_error, [1] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_value, [23:8] byte_addr, [24] byte_bad, [32:25] block_number,
    // [48:33] exec_addr, [49] exec_valid, [57:50] sum_expected,
    // [65:58] sum_read, [66] sum_ok, [82:67] error_total, [87:83] zero
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser        // [1:0] result_kind
);
    import tsd_pkg::*;

    logic        key_variant_reg;
    logic        in_valid_reg;
    tsd_item_t   in_item_reg;
    logic        m_valid_reg;
    logic [87:0] m_data_reg;
    logic [1:0]  m_user_reg;

    logic        out_free;
    logic        step;
    logic        has_result;
    tsd_result_t result;
    logic [87:0] data_next;

    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    tsd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .key_variant (key_variant_reg),
        .item        (in_item_reg),
        .has_result  (has_result),
        .result      (result)
    );

    assign data_next = {5'd0, result.error_total, result.sum_ok, result.sum_read,
                        result.sum_expected, result.exec_valid, result.exec_addr,
                        result.block_number, result.byte_bad, result.byte_addr,
                        result.data_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_variant_reg <= 1'b0;
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                key_variant_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                m_valid_reg <= has_result;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{byte_value: s_tdata, read_error: s_tuser[0],
                             frame_start: s_tuser[1]};
        end
        if (step && has_result) begin
            m_data_reg <= data_next;
            m_user_reg <= result.result_kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // An empty result register always lets a new item in.
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_user_reg == KIND_PAYLOAD || m_user_reg == KIND_STATUS ||
                         m_user_reg == KIND_FORMAT))
        else $error("illegal result kind");

    a_bad_byte_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[24]) |-> (m_data_reg[7:0] == BAD_BYTE &&
                                             m_user_reg == KIND_PAYLOAD))
        else $error("bad payload byte without the substitute value");

    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg != KIND_STATUS) |->
            (m_data_reg[66:33] == 34'd0))
        else $error("status fields set on a non-status result");

    a_sum_ok_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[66]) |-> (m_data_reg[65:58] == m_data_reg[57:50]))
        else $error("checksum flagged good but values differ");
`endif

endmodule

// File: sim/tape_subblock_descrambler_tb.sv
// ----------------------------------------------------------------------------
// Tape sub-block descrambler testbench
// Streams tape files into the descrambler. The files come from an encoder that
// scrambles chosen plaintext, and broken files and noise are mixed in. The
// results are checked field by field against a cycle-free predictor of the
// sub-block parser. The key table is switched between phases and the handshake
// pacing is varied.
// ----------------------------------------------------------------------------
module tape_subblock_descrambler_tb;

    import tsd_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int RANDOM_PER_PHASE = 150;

    typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;
    typedef enum int {BRK_ID_ZERO, BRK_HDR_ERR, BRK_OVERFLOW, BRK_CUT, BRK_NOISE} broken_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;   // [7:0] byte_value
    logic [1:0]  s_tuser     = 2'b00;   // [0] read_error, [1] frame_start
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [87:0] m_tdata;               // data_value up to error_total, see the block
    logic [1:0]  m_tuser;               // [1:0] result_kind

    tape_subblock_descrambler dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #6 aclk = ~aclk;

    tsd_item_t   tape_bytes[$];
    tsd_result_t due_results[$];

    int items_made    = 0;
    int items_taken   = 0;
    int mismatches    = 0;
    int payload_seen  = 0;
    int status_seen   = 0;
    int format_seen   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit in_taken      = 1'b0;

    // Parser state as the block should hold it.
    tsd_phase_t  parse_phase;
    logic [1:0]  hdr_pos;
    logic [7:0]  blk_id;
    logic [15:0] load_addr;
    logic [8:0]  bytes_to_go;
    logic [7:0]  key_pos;
    logic [7:0]  check_sum;
    logic [15:0] err_count;
    logic [7:0]  exec_lo_byte;
    logic [7:0]  exec_hi_byte;
    logic [1:0]  exec_seen;
    logic        key_sel;

    // Encoder state used to build well-formed files with a known checksum.
    logic        tape_key_sel = 1'b0;
    int          plain_key_pos;
    logic [7:0]  plain_sum;

    function automatic int key_len(input logic sel);
        return sel ? KEY_LEN_B : KEY_LEN_A;
    endfunction

    function automatic logic [7:0] key_at(input logic sel, input int idx);
        return sel ? KEY_B[idx] : KEY_A[idx];
    endfunction

    function automatic bit format_fail(output tsd_result_t r);
        r = '0;
        r.result_kind  = KIND_FORMAT;
        r.block_number = blk_id;
        r.error_total  = err_count;
        parse_phase    = PH_IDLE;
        return 1'b1;
    endfunction

    // Advances the parser by one tape byte; returns 1 when a result is due.
    function automatic bit descramble_step(input tsd_item_t it, output tsd_result_t r);
        int          len;
        int          k;
        logic [7:0]  v;
        logic [8:0]  blk_size;
        logic [16:0] last_addr;
        r = '0;
        if (it.frame_start) begin
            key_pos     = 8'd0;
            check_sum   = 8'd0;
            err_count   = 16'd0;
            exec_seen   = 2'b00;
            parse_phase = PH_HEADER;
            hdr_pos     = 2'd0;
        end
        case (parse_phase)
            PH_HEADER: begin
                if (it.read_error) begin
                    if (hdr_pos == 2'd0) blk_id = 8'h00;
                    return format_fail(r);
                end
                case (hdr_pos)
                    2'd0: begin
                        blk_id = it.byte_value;
                        if (it.byte_value == 8'h00) return format_fail(r);
                        hdr_pos = 2'd1;
                    end
                    2'd1: begin
                        load_addr = {8'h00, it.byte_value};
                        hdr_pos   = 2'd2;
                    end
                    2'd2: begin
                        load_addr[15:8] = it.byte_value;
                        hdr_pos         = 2'd3;
                    end
                    default: begin
                        blk_size  = (it.byte_value == 8'h00) ? FULL_SIZE : {1'b0, it.byte_value};
                        hdr_pos   = 2'd0;
                        last_addr = {1'b0, load_addr} + {8'h00, blk_size} - 17'd1;
                        if (last_addr > {1'b0, COUNT_MAX}) return format_fail(r);
                        bytes_to_go = blk_size;
                        parse_phase = PH_PAYLOAD;
                    end
                endcase
                return 1'b0;
            end
            PH_PAYLOAD: begin
                r.result_kind  = KIND_PAYLOAD;
                r.byte_addr    = load_addr;
                r.block_number = blk_id;
                if (it.read_error) begin
                    r.data_value = BAD_BYTE;
                    r.byte_bad   = 1'b1;
                    if (err_count != COUNT_MAX) err_count++;
                end else begin
                    // A key position left over from the longer table restarts at zero.
                    len = key_len(key_sel);
                    k   = (key_pos < len) ? key_pos : 0;
                    v   = it.byte_value ^ key_at(key_sel, k) ^ load_addr[15:8] ^ load_addr[7:0];
                    r.data_value = v;
                    check_sum    = check_sum ^ v;
                    k++;
                    key_pos = (k >= len) ? 8'd0 : 8'(k);
                end
                load_addr++;
                bytes_to_go--;
                if (bytes_to_go == 9'd0) begin
                    if (blk_id == 8'd1) begin
                        parse_phase = PH_EXEC_LO;
                        exec_seen   = 2'b00;
                    end else begin
                        parse_phase = PH_HEADER;
                        hdr_pos     = 2'd0;
                    end
                end
                return 1'b1;
            end
            PH_EXEC_LO: begin
                if (!it.read_error) begin
                    exec_lo_byte = it.byte_value;
                    exec_seen[0] = 1'b1;
                end
                parse_phase = PH_EXEC_HI;
                return 1'b0;
            end
            PH_EXEC_HI: begin
                if (!it.read_error) begin
                    exec_hi_byte = it.byte_value;
                    exec_seen[1] = 1'b1;
                end
                parse_phase = PH_CHECK;
                return 1'b0;
            end
            PH_CHECK: begin
                r.result_kind  = KIND_STATUS;
                r.block_number = blk_id;
                if (exec_seen == 2'b11) begin
                    r.exec_addr  = {exec_hi_byte, exec_lo_byte};
                    r.exec_valid = 1'b1;
                end
                r.sum_expected = check_sum;
                if (it.read_error) begin
                    if (err_count != COUNT_MAX) err_count++;
                    r.sum_read = BYTE_MAX;
                end else begin
                    r.sum_read = it.byte_value;
                    r.sum_ok   = (it.byte_value == check_sum);
                end
                r.error_total = err_count;
                parse_phase   = PH_IDLE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Sender: a new item goes out once the previous one has been taken.
    always @(negedge aclk) begin : tape_driver
        tsd_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (tape_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = tape_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.byte_value;
                s_tuser  <= {nxt.frame_start, nxt.read_error};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Results are checked before the item of the same edge is predicted.
    always @(posedge aclk) begin : scoreboard
        tsd_result_t want;
        tsd_result_t seen;
        tsd_item_t   got_in;
        if (!aresetn) begin
            parse_phase  = PH_HEADER;
            hdr_pos      = 2'd0;
            blk_id       = 8'h00;
            load_addr    = 16'h0000;
            bytes_to_go  = 9'd0;
            key_pos      = 8'd0;
            check_sum    = 8'h00;
            err_count    = 16'd0;
            exec_lo_byte = 8'h00;
            exec_hi_byte = 8'h00;
            exec_seen    = 2'b00;
            key_sel      = 1'b0;
            in_taken     = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result with kind %0d arrived with none expected", m_tuser);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    seen.result_kind  = tsd_kind_t'(m_tuser);
                    seen.data_value   = m_tdata[7:0];
                    seen.byte_addr    = m_tdata[23:8];
                    seen.byte_bad     = m_tdata[24];
                    seen.block_number = m_tdata[32:25];
                    seen.exec_addr    = m_tdata[48:33];
                    seen.exec_valid   = m_tdata[49];
                    seen.sum_expected = m_tdata[57:50];
                    seen.sum_read     = m_tdata[65:58];
                    seen.sum_ok       = m_tdata[66];
                    seen.error_total  = m_tdata[82:67];
                    check_field("result_kind", want.result_kind, seen.result_kind);
                    check_field("data_value", want.data_value, seen.data_value);
                    check_field("byte_addr", want.byte_addr, seen.byte_addr);
                    check_field("byte_bad", want.byte_bad, seen.byte_bad);
                    check_field("block_number", want.block_number, seen.block_number);
                    check_field("exec_addr", want.exec_addr, seen.exec_addr);
                    check_field("exec_valid", want.exec_valid, seen.exec_valid);
                    check_field("sum_expected", want.sum_expected, seen.sum_expected);
                    check_field("sum_read", want.sum_read, seen.sum_read);
                    check_field("sum_ok", want.sum_ok, seen.sum_ok);
                    check_field("error_total", want.error_total, seen.error_total);
                    case (want.result_kind)
                        KIND_PAYLOAD: payload_seen++;
                        KIND_STATUS:  status_seen++;
                        default:      format_seen++;
                    endcase
                end
            end
            if (cfg_wr_en) key_sel = cfg_wr_data;
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                got_in.byte_value  = s_tdata;
                got_in.read_error  = s_tuser[0];
                got_in.frame_start = s_tuser[1];
                if (descramble_step(got_in, want)) due_results.push_back(want);
                items_taken++;
            end
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic err, input logic fs);
        tape_bytes.push_back('{byte_value: b, read_error: err, frame_start: fs});
        items_made++;
    endtask

    // Waits until every item is taken and every result has been checked.
    task automatic drain();
        while (items_taken != items_made || due_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_key(input logic sel);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tape_key_sel = sel;
    endtask

    task automatic set_pace(input pace_t mode);
        case (mode)
            PACE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            PACE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:   begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // Scrambles one good payload byte at address a and folds its plaintext into the sum.
    task automatic add_plain(input logic [7:0] plain, input logic [15:0] a, inout tsd_item_t f[$]);
        f.push_back('{byte_value: plain ^ key_at(tape_key_sel, plain_key_pos) ^ a[15:8] ^ a[7:0],
                      read_error: 1'b0, frame_start: 1'b0});
        plain_sum = plain_sum ^ plain;
        plain_key_pos++;
        if (plain_key_pos >= key_len(tape_key_sel)) plain_key_pos = 0;
    endtask

    // Builds a chain of one to three sub-blocks ending with id 1; may cut it short.
    task automatic gen_file(input bit truncate);
        tsd_item_t   f[$];
        int          nblk;
        int          blk_size;
        int          addr;
        int          roll;
        int          keep;
        logic [15:0] a;
        logic [7:0]  id;
        plain_key_pos = 0;
        plain_sum     = 8'h00;
        nblk = $urandom_range(1, 3);
        for (int bi = 0; bi < nblk; bi++) begin
            id   = (bi == nblk - 1) ? 8'd1 : 8'($urandom_range(2, 255));
            roll = $urandom_range(99);
            if (roll < 4) blk_size = 256;
            else if (roll < 8) blk_size = $urandom_range(128, 255);
            else blk_size = $urandom_range(1, 12);
            if ($urandom_range(3) == 0) addr = 65536 - blk_size - $urandom_range(2);
            else addr = $urandom_range(65536 - blk_size);
            f.push_back('{byte_value: id, read_error: 1'b0, frame_start: (bi == 0)});
            f.push_back('{byte_value: 8'(addr), read_error: 1'b0, frame_start: 1'b0});
            f.push_back('{byte_value: 8'(addr >> 8), read_error: 1'b0, frame_start: 1'b0});
            f.push_back('{byte_value: 8'(blk_size), read_error: 1'b0, frame_start: 1'b0});
            for (int i = 0; i < blk_size; i++) begin
                a = 16'(addr + i);
                if ($urandom_range(99) < 4)
                    f.push_back('{byte_value: 8'($urandom), read_error: 1'b1, frame_start: 1'b0});
                else
                    add_plain(8'($urandom), a, f);
            end
        end
        f.push_back('{byte_value: 8'($urandom), read_error: ($urandom_range(9) == 0),
                      frame_start: 1'b0});
        f.push_back('{byte_value: 8'($urandom), read_error: ($urandom_range(9) == 0),
                      frame_start: 1'b0});
        roll = $urandom_range(99);
        if (roll < 70)
            f.push_back('{byte_value: plain_sum, read_error: 1'b0, frame_start: 1'b0});
        else
            f.push_back('{byte_value: 8'($urandom), read_error: (roll >= 90), frame_start: 1'b0});
        keep = truncate ? $urandom_range(1, f.size() - 1) : f.size();
        for (int i = 0; i < keep; i++)
            add_byte(f[i].byte_value, f[i].read_error, f[i].frame_start);
    endtask

    task automatic gen_broken();
        broken_t kind;
        int      pos;
        int      blk_size;
        int      addr;
        kind = broken_t'($urandom_range(4));
        case (kind)
            BRK_ID_ZERO: add_byte(8'h00, 1'b0, 1'b1);
            BRK_HDR_ERR: begin
                pos = $urandom_range(3);
                for (int i = 0; i < pos; i++)
                    add_byte((i == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom), 1'b0, (i == 0));
                add_byte(8'($urandom), 1'b1, (pos == 0));
            end
            BRK_OVERFLOW: begin
                blk_size = $urandom_range(1, 256);
                addr     = $urandom_range(65537 - blk_size, 65535);
                add_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
                add_byte(8'(addr), 1'b0, 1'b0);
                add_byte(8'(addr >> 8), 1'b0, 1'b0);
                add_byte(8'(blk_size), 1'b0, 1'b0);
            end
            BRK_CUT: gen_file(1'b1);
            default: begin
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'($urandom), 1'b0);
            end
        endcase
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tape_subblock_descrambler regression: fail");
        $finish;
    end

    initial begin : stimulus
        tsd_item_t  f[$];
        int         start;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_key(1'b0);
        set_pace(PACE_NONE);

        // Directed part. The first file has no frame start and ends at the top of memory.
        plain_key_pos = 0;
        plain_sum     = 8'h00;
        add_byte(8'd1, 1'b0, 1'b0);
        add_byte(8'hFE, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'd2, 1'b0, 1'b0);
        add_plain(8'hA5, 16'hFFFE, f);
        add_byte(f[0].byte_value, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'h34, 1'b0, 1'b0);
        add_byte(8'h12, 1'b0, 1'b0);
        add_byte(plain_sum, 1'b0, 1'b0);
        // Ignored while idle, then id zero, a bad address byte and an end past memory.
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'd7, 1'b0, 1'b1);
        add_byte(8'h55, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hAB, 1'b1, 1'b1);
        // Bad payload, bad low execution byte and an unreadable checkbyte.
        add_byte(8'd1, 1'b0, 1'b1);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'd1, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        drain();

        // The key table shrinks in the middle of a file with the key position past its end.
        write_key(1'b1);
        add_byte(8'd5, 1'b0, 1'b1);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h10, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        repeat (210) add_byte(8'($urandom), 1'b0, 1'b0);
        drain();
        write_key(1'b0);
        repeat (46) add_byte(8'($urandom), ($urandom_range(9) == 0), 1'b0);
        add_byte(8'd1, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h20, 1'b0, 1'b0);
        add_byte(8'd1, 1'b0, 1'b0);
        repeat (4) add_byte(8'($urandom), 1'b0, 1'b0);
        drain();

        // Random files and broken input under each pacing with both key tables.
        for (int ph = 0; ph < 8; ph++) begin
            write_key(ph >= 4);
            set_pace(pace_t'(ph % 4));
            start = items_made;
            while (items_made - start < RANDOM_PER_PHASE) begin
                if ($urandom_range(99) < 75) gen_file(1'b0);
                else gen_broken();
            end
            drain();
        end

        $display("Streamed %0d tape items over both key tables, four pacing modes and %0d cycles.",
                 items_taken, cycle_count);
        $display("Checked %0d payload, %0d status and %0d format error results; %0d mismatches.",
                 payload_seen, status_seen, format_seen, mismatches);
        if (mismatches == 0) begin
            $display("tape_subblock_descrambler regression: pass");
        end else begin
            $display("tape_subblock_descrambler regression: fail");
        end
        $finish;
    end

endmodule

// File: tape_subblock_descrambler.f
design/tsd_pkg.sv
design/tsd_core.sv
design/tape_subblock_descrambler.sv
sim/tape_subblock_descrambler_tb.sv
